// ===== sv/b32d_pkg.sv =====
// ============================================================================
// b32d_pkg
// Types and character constants shared by the base32 decoder files.
// ============================================================================
package b32d_pkg;

    localparam int unsigned SymbolWidth = 8;
    localparam int unsigned ValueWidth  = 5;
    localparam int unsigned BufWidth    = 12;
    localparam int unsigned HeldWidth   = 4;
    localparam int unsigned CountWidth  = 8;

    localparam logic [SymbolWidth-1:0] ChrNul     = 8'h00;
    localparam logic [SymbolWidth-1:0] ChrTab     = 8'h09;
    localparam logic [SymbolWidth-1:0] ChrLf      = 8'h0A;
    localparam logic [SymbolWidth-1:0] ChrCr      = 8'h0D;
    localparam logic [SymbolWidth-1:0] ChrSpace   = 8'h20;
    localparam logic [SymbolWidth-1:0] ChrNbsp    = 8'hA0;
    localparam logic [SymbolWidth-1:0] ChrPad     = 8'h3D;
    localparam logic [SymbolWidth-1:0] ChrZero    = 8'h30;
    localparam logic [SymbolWidth-1:0] ChrOne     = 8'h31;
    localparam logic [SymbolWidth-1:0] ChrEight   = 8'h38;
    localparam logic [SymbolWidth-1:0] ChrUpperO  = 8'h4F;
    localparam logic [SymbolWidth-1:0] ChrUpperL  = 8'h4C;
    localparam logic [SymbolWidth-1:0] ChrUpperB  = 8'h42;
    localparam logic [SymbolWidth-1:0] ChrUpperA  = 8'h41;
    localparam logic [SymbolWidth-1:0] ChrUpperZ  = 8'h5A;
    localparam logic [SymbolWidth-1:0] ChrLowerA  = 8'h61;
    localparam logic [SymbolWidth-1:0] ChrLowerZ  = 8'h7A;
    localparam logic [SymbolWidth-1:0] ChrTwo     = 8'h32;
    localparam logic [SymbolWidth-1:0] ChrSeven   = 8'h37;
    localparam logic [SymbolWidth-1:0] LetterMask = 8'h1F;

    localparam logic [HeldWidth-1:0]  ByteBits    = 4'd8;
    localparam logic [HeldWidth-1:0]  SymbolBits  = 4'd5;
    localparam logic [CountWidth-1:0] MaxBytesRst = 8'd20;

    typedef logic [SymbolWidth-1:0] symbol_t;
    typedef logic [CountWidth-1:0]  count_t;

    // registered input item handed to the decode core
    typedef struct packed {
        logic    valid;
        symbol_t symbol;
        logic    start_req;
    } item_t;

    // classification of one character
    typedef struct packed {
        logic                  is_nul;
        logic                  is_skip;
        logic                  is_valid;
        logic [ValueWidth-1:0] value;
    } sym_class_t;

endpackage

// ===== sv/b32d_in_if.sv =====
// ============================================================================
// b32d_in_if
// Character channel: valid/ready handshake with symbol and start flag.
// ============================================================================
interface b32d_in_if;
    import b32d_pkg::*;

    logic    valid;
    logic    ready;
    symbol_t symbol;
    logic    start_req;

    modport source (output valid, output symbol, output start_req, input ready);
    modport sink   (input valid, input symbol, input start_req, output ready);

endinterface

// ===== sv/b32d_out_if.sv =====
// ============================================================================
// b32d_out_if
// Decoded byte channel: valid/ready handshake with byte, index and flags.
// ============================================================================
interface b32d_out_if;
    import b32d_pkg::*;

    logic    valid;
    logic    ready;
    symbol_t byte_out;
    count_t  byte_index;
    logic    error;
    logic    last;

    modport source (output valid, output byte_out, output byte_index,
                    output error, output last, input ready);
    modport sink   (input valid, input byte_out, input byte_index,
                    input error, input last, output ready);

endinterface

// ===== sv/b32d_symbol_map.sv =====
// ============================================================================
// b32d_symbol_map
// Classifies one character: end of string, skipped, or base32 value 0-31.
// ============================================================================
module b32d_symbol_map
(
    input  b32d_pkg::symbol_t    symbol,
    output b32d_pkg::sym_class_t sym_class
);
    import b32d_pkg::*;

    symbol_t c;
    logic    is_letter;
    logic    is_digit;

    always_comb
    begin
        // fold the look-alike digits onto their letters
        priority if (symbol == ChrZero)
        begin
            c = ChrUpperO;
        end
        else if (symbol == ChrOne)
        begin
            c = ChrUpperL;
        end
        else if (symbol == ChrEight)
        begin
            c = ChrUpperB;
        end
        else
        begin
            c = symbol;
        end
    end

    assign is_letter = ((c >= ChrUpperA) && (c <= ChrUpperZ)) ||
                       ((c >= ChrLowerA) && (c <= ChrLowerZ));
    assign is_digit  = (c >= ChrTwo) && (c <= ChrSeven);

    always_comb
    begin
        sym_class.is_nul   = (symbol == ChrNul);
        sym_class.is_skip  = (symbol == ChrSpace) || (symbol == ChrNbsp) ||
                             (symbol == ChrTab)   || (symbol == ChrLf)   ||
                             (symbol == ChrCr)    || (symbol == ChrPad);
        sym_class.is_valid = is_letter || is_digit;
        // digits 2-7 land on 26-31, i.e. 24 plus the low three bits
        if (is_digit)
        begin
            sym_class.value = {2'b11, c[2:0]};
        end
        else
        begin
            sym_class.value = ValueWidth'((c & LetterMask) - 8'd1);
        end
    end

endmodule

// ===== sv/b32d_decode_core.sv =====
// ============================================================================
// b32d_decode_core
// Bit buffer, byte counter and stop flag; one item a cycle when the result
// register is free or being drained; decoded bytes go into that register.
// ============================================================================
module b32d_decode_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  b32d_pkg::item_t      item,
    input  b32d_pkg::sym_class_t sym_class,
    input  b32d_pkg::count_t     max_bytes,
    output logic                 take,
    b32d_out_if.source           out_ch
);
    import b32d_pkg::*;

    logic [BufWidth-1:0]  buf_reg,   buf_next;
    logic [HeldWidth-1:0] held_reg,  held_next;
    count_t               count_reg, count_next;
    logic                 stop_reg,  stop_next;

    logic    out_valid_reg, out_valid_next;
    symbol_t out_byte_reg,  out_byte_next;
    count_t  out_index_reg, out_index_next;
    logic    out_err_reg,   out_err_next;
    logic    out_last_reg,  out_last_next;

    // state as seen by this item, after a start request clears it
    logic [BufWidth-1:0]  cur_buf;
    logic [HeldWidth-1:0] cur_held;
    count_t               cur_count;
    logic                 cur_stop;

    logic [BufWidth-1:0]  shifted;
    logic [HeldWidth-1:0] held_sum;
    logic [HeldWidth-1:0] shift_amt;
    count_t               count_inc;
    logic                 emit;

    // advance when the result register is free or being drained
    assign take = item.valid && (!out_valid_reg || out_ch.ready);

    assign cur_buf   = item.start_req ? '0 : buf_reg;
    assign cur_held  = item.start_req ? '0 : held_reg;
    assign cur_count = item.start_req ? '0 : count_reg;
    assign cur_stop  = item.start_req ? 1'b0 : stop_reg;

    assign shifted   = {cur_buf[BufWidth-ValueWidth-1:0], sym_class.value};
    assign held_sum  = cur_held + SymbolBits;
    assign shift_amt = held_sum - ByteBits;
    assign count_inc = cur_count + 8'd1;

    always_comb
    begin
        buf_next       = cur_buf;
        held_next      = cur_held;
        count_next     = cur_count;
        stop_next      = cur_stop;
        emit           = 1'b0;
        out_byte_next  = '0;
        out_index_next = cur_count;
        out_err_next   = 1'b0;
        out_last_next  = 1'b0;

        priority if (cur_stop)
        begin
            // drop characters until the next start
        end
        else if ((cur_count >= max_bytes) || sym_class.is_nul)
        begin
            stop_next = 1'b1;
        end
        else if (sym_class.is_skip)
        begin
            // skipped character: hold state
        end
        else if (!sym_class.is_valid)
        begin
            stop_next    = 1'b1;
            emit         = 1'b1;
            out_err_next = 1'b1;
        end
        else
        begin
            buf_next = shifted;
            if (held_sum >= ByteBits)
            begin
                held_next     = shift_amt;
                emit          = 1'b1;
                out_byte_next = SymbolWidth'(shifted >> shift_amt);
                count_next    = count_inc;
                out_last_next = (count_inc >= max_bytes);
                stop_next     = (count_inc >= max_bytes);
            end
            else
            begin
                held_next = held_sum;
            end
        end

        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            stop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                buf_reg   <= buf_next;
                held_reg  <= held_next;
                count_reg <= count_next;
                stop_reg  <= stop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_byte_reg  <= out_byte_next;
            out_index_reg <= out_index_next;
            out_err_reg   <= out_err_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.byte_out   = out_byte_reg;
    assign out_ch.byte_index = out_index_reg;
    assign out_ch.error      = out_err_reg;
    assign out_ch.last       = out_last_reg;

endmodule

// ===== sv/base32_decoder_unit.sv =====
// Path: a character goes into the input register, then is decoded into the
// result register.
// Throughput: one character per cycle; the bit-buffer update is a single
// shift-and-or step, so the only stall is a full result register.
// Reset clears the bit buffer, byte count and stop flag; max_bytes resets to 20.
// ============================================================================
// base32_decoder_unit
// Base32 text decoder: one character in, zero or one decoded byte out.
// ============================================================================
module base32_decoder_unit
(
    input  logic             clk,
    input  logic             rst_n,
    b32d_in_if.sink          in_ch,
    b32d_out_if.source       out_ch,
    input  logic             cfg_we,
    input  b32d_pkg::count_t cfg_wdata
);
    import b32d_pkg::*;

    logic       in_valid_reg, in_valid_next;
    symbol_t    in_symbol_reg;
    logic       in_start_reg;
    count_t     max_bytes_reg;
    item_t      item;
    sym_class_t sym_class;
    logic       take;

    assign in_ch.ready   = !in_valid_reg || take;
    assign in_valid_next = in_ch.valid ? 1'b1 : (take ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            max_bytes_reg <= MaxBytesRst;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_valid_next;
            end
            if (cfg_we)
            begin
                max_bytes_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_symbol_reg <= in_ch.symbol;
            in_start_reg  <= in_ch.start_req;
        end
    end

    assign item.valid     = in_valid_reg;
    assign item.symbol    = in_symbol_reg;
    assign item.start_req = in_start_reg;

    b32d_symbol_map u_symbol_map
    (
        .symbol    (item.symbol),
        .sym_class (sym_class)
    );

    b32d_decode_core u_decode_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .sym_class (sym_class),
        .max_bytes (max_bytes_reg),
        .take      (take),
        .out_ch    (out_ch)
    );

endmodule
